>>> hw/rtl/tses_pkg.sv
`default_nettype none
package tses_pkg;

	localparam logic [1:0] STAGE_SHUTDOWN = 2'd0;
	localparam logic [1:0] STAGE_STARTUP  = 2'd1;
	localparam logic [1:0] STAGE_CHAOS    = 2'd2;
	localparam logic [1:0] STAGE_SLEW     = 2'd3;

	localparam logic [2:0] PART_SETTLE = 3'd0;
	localparam logic [2:0] PART_PITCH  = 3'd1;
	localparam logic [2:0] PART_ROLL   = 3'd2;
	localparam logic [2:0] PART_THR    = 3'd3;
	localparam logic [2:0] PART_HOLD   = 3'd4;

	localparam logic [2:0] REG_STARTUP_MS   = 3'd0;
	localparam logic [2:0] REG_CHAOS_MS     = 3'd1;
	localparam logic [2:0] REG_BURST_GAP_MS = 3'd2;
	localparam logic [2:0] REG_BURST_LEN_MS = 3'd3;
	localparam logic [2:0] REG_SETTLE_STEPS = 3'd4;
	localparam logic [2:0] REG_SWEEP_STEPS  = 3'd5;

	localparam logic [15:0] RST_STARTUP_MS   = 16'd5000;
	localparam logic [23:0] RST_CHAOS_MS     = 24'd50000;
	localparam logic [15:0] RST_BURST_GAP_MS = 16'd12000;
	localparam logic [15:0] RST_BURST_LEN_MS = 16'd400;
	localparam logic [11:0] RST_SETTLE_STEPS = 12'd801;
	localparam logic [11:0] RST_SWEEP_STEPS  = 12'd1601;

	// low 32 bits of the ms-to-turns constant, the upper part is 64
	localparam logic [31:0] KQ16_LO = 32'd2870523239;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int C_SMALL         = 1638;
	localparam int C_MED           = 4915;
	localparam int C_ROLLING       = 6554;
	localparam int C_LARGE         = 13107;
	localparam int C_BASE          = 18022;
	localparam int C_STARTUP       = 21299;
	localparam int C_SWEEP         = 26214;
	localparam int C_SWING         = 11469;
	localparam int C_SERVO_MAX     = 29491;
	localparam int C_THR_MIN       = 8192;
	localparam int C_THR_MAX       = 31130;
	localparam int C_SWEEP_THR_MIN = 6554;
	localparam int C_SWEEP_THR_MAX = 32767;

	typedef enum logic [2:0] {
		JOB_DIRECT,
		JOB_CHAOS,
		JOB_PITCH,
		JOB_ROLL,
		JOB_THR
	} job_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_NOW_K,
		MUL_X_K,
		MUL_S12_S6,
		MUL_S31_S12,
		MUL_PROD_MED,
		MUL_PROD_SMALL,
		MUL_ROLL,
		MUL_LARGE,
		MUL_SWEEP
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_CLR,
		ACC_ADD,
		ACC_ADD_SH,
		ACC_ADD_BURST
	} acc_op_t;

	typedef enum logic [2:0] {
		PH_S12,
		PH_S6,
		PH_S31,
		PH_S155,
		PH_BURST,
		PH_SWEEP
	} ph_sel_t;

	typedef struct packed {
		logic    take;
		logic    eval;
		mul_op_t mul_op;
		logic    ld_p;
		logic    ld_e;
		logic    sin_issue;
		ph_sel_t sin_sel;
		acc_op_t acc_op;
		logic    ld_small;
		logic    finish;
		logic    publish;
	} ctrl_cmd_t;

	typedef struct packed {
		job_t job_next;
	} dp_status_t;

	function automatic logic signed [19:0] sat20(logic signed [19:0] v,
		logic signed [19:0] lo, logic signed [19:0] hi);
		logic signed [19:0] r;
		r = v;
		if (v < lo) r = lo;
		if (v > hi) r = hi;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tses_sine.sv
`default_nettype none
module tses_sine import tses_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               issue,
	input  wire ph_sel_t            tag,
	input  wire logic [31:0]        phase,
	output logic                    wr_valid,
	output ph_sel_t                 wr_tag,
	output logic signed [15:0]      wr_value
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = 30 + AW;

	typedef logic [14:0] rom_t [0:SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		longint unsigned a;
		longint unsigned a2;
		longint unsigned term;
		longint unsigned v;
		longint s;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			a = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			a2 = (a * a) >> 30;
			term = a;
			s = longint'(a);
			term = ((term * a2) >> 30) / 6;
			s = s - longint'(term);
			term = ((term * a2) >> 30) / 20;
			s = s + longint'(term);
			term = ((term * a2) >> 30) / 42;
			s = s - longint'(term);
			term = ((term * a2) >> 30) / 72;
			s = s + longint'(term);
			term = ((term * a2) >> 30) / 110;
			s = s - longint'(term);
			if (s < 0) s = 0;
			if (s > 64'sd1073741824) s = 64'sd1073741824;
			v = (longint'(s) * 32767 + 536870912) >> 30;
			if (v > 32767) v = 32767;
			r[i] = 15'(v);
		end
		return r;
	endfunction

	localparam rom_t SIN_ROM = build_rom();

	logic           vld_s1, vld_s2, vld_s3;
	ph_sel_t        tag_s1, tag_s2, tag_s3;
	logic [31:0]    ph_s1;
	logic           neg_s2, neg_s3;
	logic [AW-1:0]  addr_s2;
	logic [14:0]    rom_s3;
	logic [PW-1:0]  scaled;
	logic [AW-1:0]  idx;
	logic [AW-1:0]  addr;

	always_comb begin
		scaled = PW'(ph_s1[29:0]) * PW'(SINE_TABLE_DEPTH);
		idx = scaled[PW-1:30];
		addr = ph_s1[30] ? (AW'(SINE_TABLE_DEPTH) - idx) : idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= tag;
		ph_s1 <= phase;
		tag_s2 <= tag_s1;
		neg_s2 <= ph_s1[31];
		addr_s2 <= addr;
		tag_s3 <= tag_s2;
		neg_s3 <= neg_s2;
		rom_s3 <= SIN_ROM[addr_s2];
	end

	assign wr_valid = vld_s3;
	assign wr_tag = tag_s3;
	assign wr_value = neg_s3 ? -$signed({1'b0, rom_s3}) : $signed({1'b0, rom_s3});

endmodule
`default_nettype wire

>>> hw/rtl/tses_ctrl.sv
`default_nettype none
module tses_ctrl import tses_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EVAL  = 5'b00010,
		S_CHAOS = 5'b00100,
		S_SWEEP = 5'b01000,
		S_PUB   = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	logic [3:0]  step_q, step_d;
	logic        out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_op = MUL_NONE;
		cmd.sin_sel = PH_S12;
		cmd.acc_op = ACC_HOLD;
		state_d = state_q;
		step_d = step_q + 4'd1;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				step_d = 4'd0;
				priority if (status.job_next == JOB_DIRECT) state_d = S_PUB;
				else if (status.job_next == JOB_CHAOS) state_d = S_CHAOS;
				else state_d = S_SWEEP;
			end
			S_CHAOS: begin
				unique case (step_q)
					4'd0: begin
						cmd.mul_op = MUL_NOW_K;
						cmd.acc_op = ACC_CLR;
					end
					4'd1: begin
						cmd.mul_op = MUL_X_K;
						cmd.ld_p = 1'b1;
					end
					4'd2: begin
						cmd.ld_e = 1'b1;
						cmd.sin_issue = 1'b1;
						cmd.sin_sel = PH_S12;
					end
					4'd3: begin
						cmd.sin_issue = 1'b1;
						cmd.sin_sel = PH_S6;
					end
					4'd4: begin
						cmd.sin_issue = 1'b1;
						cmd.sin_sel = PH_S31;
					end
					4'd5: begin
						cmd.sin_issue = 1'b1;
						cmd.sin_sel = PH_S155;
					end
					4'd6: begin
						cmd.sin_issue = 1'b1;
						cmd.sin_sel = PH_BURST;
					end
					4'd7: cmd.mul_op = MUL_S12_S6;
					4'd8: cmd.mul_op = MUL_PROD_MED;
					4'd9: begin
						cmd.mul_op = MUL_S31_S12;
						cmd.acc_op = ACC_ADD;
					end
					4'd10: cmd.mul_op = MUL_PROD_SMALL;
					4'd11: begin
						cmd.mul_op = MUL_ROLL;
						cmd.acc_op = ACC_ADD;
						cmd.ld_small = 1'b1;
					end
					4'd12: begin
						cmd.mul_op = MUL_LARGE;
						cmd.acc_op = ACC_ADD_SH;
					end
					4'd13: cmd.acc_op = ACC_ADD_BURST;
					4'd14: begin
						cmd.finish = 1'b1;
						state_d = S_PUB;
					end
					default: ;
				endcase
			end
			S_SWEEP: begin
				unique case (step_q)
					4'd0: begin
						cmd.mul_op = MUL_X_K;
						cmd.acc_op = ACC_CLR;
					end
					4'd1: cmd.ld_e = 1'b1;
					4'd2: begin
						cmd.sin_issue = 1'b1;
						cmd.sin_sel = PH_SWEEP;
					end
					4'd6: cmd.mul_op = MUL_SWEEP;
					4'd7: cmd.acc_op = ACC_ADD_SH;
					4'd8: begin
						cmd.finish = 1'b1;
						state_d = S_PUB;
					end
					default: ;
				endcase
			end
			S_PUB: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			if (cmd.publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/tses_dp.sv
`default_nettype none
module tses_dp import tses_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctrl_cmd_t          cmd,
	output dp_status_t              status,
	input  wire logic               stop_request,
	input  wire logic [31:0]        now_ms,
	input  wire logic               cfg_valid,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data,
	output logic                    motors_on,
	output logic                    arm_pulse,
	output logic [1:0]              stage,
	output logic                    angle_boost,
	output logic [14:0]             throttle,
	output logic signed [15:0]      pitch,
	output logic signed [15:0]      roll
);

	logic [15:0] startup_ms_q, burst_gap_ms_q, burst_len_ms_q;
	logic [23:0] chaos_ms_q;
	logic [11:0] settle_steps_q, sweep_steps_q;

	logic [1:0]  stage_q;
	logic        sdone_q, bact_q;
	logic [31:0] sst_q, bst_q;
	logic [2:0]  part_q;
	logic [11:0] sc_q;

	logic        stop_q;
	logic [31:0] now_q;
	job_t        job_q;
	logic [31:0] x_q;
	logic        bon_q;

	logic               res_on_q, res_arm_q, res_boost_q;
	logic [1:0]         res_stage_q;
	logic [14:0]        res_thr_q;
	logic signed [15:0] res_pitch_q, res_roll_q;

	logic signed [65:0] prod_q;
	logic [71:0]        p_q, e_q;
	logic signed [47:0] acc_q, sm_q;
	logic signed [15:0] s12_q, s6_q, s31_q, s155_q, sb_q, ssw_q;

	// tick evaluation
	logic [1:0]         e_stage;
	logic               e_sdone, e_bact, e_arm, e_boost, e_on, e_bon;
	logic [31:0]        e_sst, e_bst, e_x, el;
	logic [2:0]         e_part;
	logic [11:0]        e_sc;
	logic [14:0]        e_thr;
	logic signed [15:0] e_pitch, e_roll;
	job_t               e_job;

	always_comb begin
		e_stage = stage_q;
		e_sdone = sdone_q;
		e_sst = sst_q;
		e_bst = bst_q;
		e_bact = bact_q;
		e_part = part_q;
		e_sc = sc_q;
		e_arm = 1'b0;
		e_boost = 1'b0;
		e_on = 1'b1;
		e_thr = 15'd0;
		e_pitch = 16'sd0;
		e_roll = 16'sd0;
		e_job = JOB_DIRECT;
		e_x = 32'd0;
		e_bon = 1'b0;
		el = now_q - bst_q;
		if (stop_q) begin
			e_stage = STAGE_SHUTDOWN;
			e_sst = now_q;
			e_on = 1'b0;
		end else begin
			if (e_stage == STAGE_SHUTDOWN) begin
				e_arm = 1'b1;
				e_stage = STAGE_STARTUP;
				e_sst = now_q;
				e_bst = now_q;
				e_sdone = 1'b0;
			end
			if (e_stage == STAGE_STARTUP && e_sdone) begin
				e_stage = STAGE_CHAOS;
				e_sst = now_q;
				e_bst = now_q;
			end else if (e_stage == STAGE_CHAOS && (now_q - e_sst) > 32'(chaos_ms_q)) begin
				e_stage = STAGE_SLEW;
				e_part = PART_SETTLE;
				e_sc = 12'd0;
			end
			el = now_q - e_bst;
			unique case (e_stage)
				STAGE_STARTUP: begin
					e_thr = 15'(C_STARTUP);
					e_boost = 1'b1;
					if ((now_q - e_sst) > 32'(startup_ms_q)) begin
						e_sdone = 1'b1;
						e_sst = now_q;
						e_bst = now_q;
					end
				end
				STAGE_CHAOS: begin
					e_job = JOB_CHAOS;
					e_boost = 1'b1;
					e_x = el;
					e_bon = e_bact;
					if (e_bact) begin
						if (el >= 32'(burst_len_ms_q)) begin
							e_bact = 1'b0;
							e_bst = now_q;
						end
					end else if (el >= 32'(burst_gap_ms_q)) begin
						e_bact = 1'b1;
						e_bst = now_q;
					end
				end
				STAGE_SLEW: begin
					e_thr = 15'(C_BASE);
					e_x = 32'(e_sc);
					unique case (e_part)
						PART_SETTLE: begin
							e_boost = 1'b1;
							if (e_sc >= settle_steps_q) begin
								e_part = PART_PITCH;
								e_sc = 12'd0;
								e_sst = now_q;
								e_bst = now_q;
							end else e_sc = e_sc + 12'd1;
						end
						PART_PITCH, PART_ROLL: begin
							e_job = (e_part == PART_PITCH) ? JOB_PITCH : JOB_ROLL;
							if (e_sc >= sweep_steps_q) begin
								e_sc = 12'd0;
								e_part = e_part + 3'd1;
							end else e_sc = e_sc + 12'd1;
						end
						PART_THR: begin
							e_job = JOB_THR;
							if (e_sc >= settle_steps_q) begin
								e_sc = 12'd0;
								e_part = PART_HOLD;
							end else e_sc = e_sc + 12'd1;
						end
						default: begin
							e_boost = 1'b1;
							if (e_sc >= settle_steps_q) begin
								e_sc = 12'd0;
								e_sst = now_q;
								e_bst = now_q;
								e_stage = STAGE_CHAOS;
							end else e_sc = e_sc + 12'd1;
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	assign status.job_next = e_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_ms_q <= RST_STARTUP_MS;
			chaos_ms_q <= RST_CHAOS_MS;
			burst_gap_ms_q <= RST_BURST_GAP_MS;
			burst_len_ms_q <= RST_BURST_LEN_MS;
			settle_steps_q <= RST_SETTLE_STEPS;
			sweep_steps_q <= RST_SWEEP_STEPS;
			stage_q <= STAGE_SHUTDOWN;
			sdone_q <= 1'b0;
			sst_q <= 32'd0;
			bst_q <= 32'd0;
			bact_q <= 1'b0;
			part_q <= PART_SETTLE;
			sc_q <= 12'd0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_STARTUP_MS:   startup_ms_q <= cfg_data[15:0];
					REG_CHAOS_MS:     chaos_ms_q <= cfg_data;
					REG_BURST_GAP_MS: burst_gap_ms_q <= cfg_data[15:0];
					REG_BURST_LEN_MS: burst_len_ms_q <= cfg_data[15:0];
					REG_SETTLE_STEPS: settle_steps_q <= cfg_data[11:0];
					REG_SWEEP_STEPS:  sweep_steps_q <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (cmd.eval) begin
				stage_q <= e_stage;
				sdone_q <= e_sdone;
				sst_q <= e_sst;
				bst_q <= e_bst;
				bact_q <= e_bact;
				part_q <= e_part;
				sc_q <= e_sc;
			end
		end
	end

	// shared multiplier
	logic signed [32:0] mul_a, mul_b;

	always_comb begin
		mul_a = 33'sd0;
		mul_b = 33'sd0;
		unique case (cmd.mul_op)
			MUL_NOW_K: begin
				mul_a = $signed({1'b0, now_q});
				mul_b = $signed({1'b0, KQ16_LO});
			end
			MUL_X_K: begin
				mul_a = $signed({1'b0, x_q});
				mul_b = $signed({1'b0, KQ16_LO});
			end
			MUL_S12_S6: begin
				mul_a = 33'(s12_q);
				mul_b = 33'(s6_q);
			end
			MUL_S31_S12: begin
				mul_a = 33'(s31_q);
				mul_b = 33'(s12_q);
			end
			MUL_PROD_MED: begin
				mul_a = $signed(prod_q[32:0]);
				mul_b = 33'(C_MED);
			end
			MUL_PROD_SMALL: begin
				mul_a = $signed(prod_q[32:0]);
				mul_b = 33'(C_SMALL);
			end
			MUL_ROLL: begin
				mul_a = 33'(s155_q);
				mul_b = 33'(C_ROLLING);
			end
			MUL_LARGE: begin
				mul_a = 33'(sb_q);
				mul_b = 33'(C_LARGE);
			end
			MUL_SWEEP: begin
				mul_a = 33'(ssw_q);
				mul_b = (job_q == JOB_THR) ? 33'(C_SWING) : 33'(C_SWEEP);
			end
			default: ;
		endcase
	end

	// phase selection
	logic [47:0] q31;
	logic [50:0] q5;
	logic [31:0] phase;

	always_comb begin
		q31 = p_q[47:0] + {p_q[45:0], 2'b00};
		q5 = e_q[50:0] + {e_q[48:0], 2'b00};
		unique case (cmd.sin_sel)
			PH_S12:   phase = p_q[46:15];
			PH_S6:    phase = p_q[47:16];
			PH_S31:   phase = q31[47:16];
			PH_S155:  phase = p_q[49:18];
			PH_BURST: phase = e_q[47:16];
			PH_SWEEP: phase = (job_q == JOB_THR) ? q5[49:18] : q5[50:19];
			default:  phase = 32'd0;
		endcase
	end

	logic               sin_wr;
	ph_sel_t            sin_tag;
	logic signed [15:0] sin_val;

	tses_sine #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_sine (
		.clk(clk),
		.arst_n(arst_n),
		.issue(cmd.sin_issue),
		.tag(cmd.sin_sel),
		.phase(phase),
		.wr_valid(sin_wr),
		.wr_tag(sin_tag),
		.wr_value(sin_val)
	);

	// result rounding and limits
	logic signed [47:0] acc_r, sm_r;
	logic signed [17:0] rnd, rnd_sm;
	logic signed [19:0] lim_servo, lim_thr, lim_sweep, lim_swthr;

	always_comb begin
		acc_r = acc_q + 48'sd536870912;
		sm_r = sm_q + 48'sd536870912;
		rnd = acc_r[47:30];
		rnd_sm = sm_r[47:30];
		lim_servo = sat20(20'(rnd), -20'(C_SERVO_MAX), 20'(C_SERVO_MAX));
		lim_thr = sat20(20'(C_BASE) + 20'(rnd_sm), 20'(C_THR_MIN), 20'(C_THR_MAX));
		lim_sweep = sat20(20'(rnd), -20'(C_SWEEP), 20'(C_SWEEP));
		lim_swthr = sat20(20'(C_BASE) + 20'(rnd), 20'(C_SWEEP_THR_MIN),
			20'(C_SWEEP_THR_MAX));
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.take) begin
			stop_q <= stop_request;
			now_q <= now_ms;
		end
		if (cmd.ld_p) p_q <= {2'b00, now_q, 38'd0} + {8'd0, prod_q[63:0]};
		if (cmd.ld_e) e_q <= {2'b00, x_q, 38'd0} + {8'd0, prod_q[63:0]};
		unique case (cmd.acc_op)
			ACC_CLR:       acc_q <= 48'sd0;
			ACC_ADD:       acc_q <= acc_q + $signed(prod_q[47:0]);
			ACC_ADD_SH:    acc_q <= acc_q + $signed({prod_q[32:0], 15'd0});
			ACC_ADD_BURST: if (bon_q) acc_q <= acc_q + $signed({prod_q[32:0], 15'd0});
			default: ;
		endcase
		if (cmd.ld_small) sm_q <= $signed(prod_q[47:0]);
		if (sin_wr) begin
			unique case (sin_tag)
				PH_S12:   s12_q <= sin_val;
				PH_S6:    s6_q <= sin_val;
				PH_S31:   s31_q <= sin_val;
				PH_S155:  s155_q <= sin_val;
				PH_BURST: sb_q <= sin_val;
				PH_SWEEP: ssw_q <= sin_val;
				default: ;
			endcase
		end
		if (cmd.eval) begin
			job_q <= e_job;
			x_q <= e_x;
			bon_q <= e_bon;
			res_on_q <= e_on;
			res_arm_q <= e_arm;
			res_stage_q <= e_stage;
			res_boost_q <= e_boost;
			res_thr_q <= e_thr;
			res_pitch_q <= e_pitch;
			res_roll_q <= e_roll;
		end
		if (cmd.finish) begin
			unique case (job_q)
				JOB_CHAOS: begin
					res_pitch_q <= lim_servo[15:0];
					res_roll_q <= lim_servo[15:0];
					res_thr_q <= lim_thr[14:0];
				end
				JOB_PITCH: res_pitch_q <= lim_sweep[15:0];
				JOB_ROLL:  res_roll_q <= lim_sweep[15:0];
				JOB_THR:   res_thr_q <= lim_swthr[14:0];
				default: ;
			endcase
		end
		if (cmd.publish) begin
			motors_on <= res_on_q;
			arm_pulse <= res_arm_q;
			stage <= res_stage_q;
			angle_boost <= res_boost_q;
			throttle <= res_thr_q;
			pitch <= res_pitch_q;
			roll <= res_roll_q;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/test_stand_excitation_sequencer_unit.sv
// a request is accepted in idle; shutdown, startup, settle and hold ticks are published
// from their evaluation alone, while sweep and chaos ticks also use the shared 33x33
// multiplier and the sine table read pipeline; one request at a time, the next accepted
// only after the last is published, and publishing waits while the previous result stalls
// reset: asynchronous, config registers return to defaults, sequence returns to shutdown
`default_nettype none
module test_stand_excitation_sequencer_unit import tses_pkg::*; #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               stop_request,
	input  wire logic [31:0]        now_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    motors_on,
	output logic                    arm_pulse,
	output logic [1:0]              stage,
	output logic                    angle_boost,
	output logic [14:0]             throttle,
	output logic signed [15:0]      pitch,
	output logic signed [15:0]      roll,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	tses_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.cmd(cmd)
	);

	tses_dp #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.stop_request(stop_request),
		.now_ms(now_ms),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.motors_on(motors_on),
		.arm_pulse(arm_pulse),
		.stage(stage),
		.angle_boost(angle_boost),
		.throttle(throttle),
		.pitch(pitch),
		.roll(roll)
	);

endmodule
`default_nettype wire

>>> hw/rtl/tses_checker.sv
`default_nettype none
module tses_checker import tses_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               motors_on,
	input wire logic               arm_pulse,
	input wire logic [1:0]         stage,
	input wire logic [14:0]        throttle,
	input wire logic signed [15:0] pitch,
	input wire logic signed [15:0] roll
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(throttle) && $stable(pitch))
		else $error("result changed while stalled");

	a_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !motors_on |-> stage == STAGE_SHUTDOWN && throttle == 15'd0
			&& pitch == 16'sd0 && roll == 16'sd0 && !arm_pulse)
		else $error("shutdown result not idle");

	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && arm_pulse |-> motors_on && stage == STAGE_STARTUP)
		else $error("arm outside startup");

	a_startup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stage == STAGE_STARTUP |-> throttle == 15'(C_STARTUP))
		else $error("startup throttle wrong");

	a_chaos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stage == STAGE_CHAOS |-> pitch == roll)
		else $error("chaos pitch and roll differ");

endmodule

bind test_stand_excitation_sequencer_unit tses_checker u_tses_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.motors_on(motors_on),
	.arm_pulse(arm_pulse),
	.stage(stage),
	.throttle(throttle),
	.pitch(pitch),
	.roll(roll)
);
`default_nettype wire

>>> dv/tb_test_stand_excitation_sequencer_unit.sv
`default_nettype none
module tb_test_stand_excitation_sequencer_unit;
	import tses_pkg::*;

	localparam int DEPTH = 1024;
	localparam int STALL_LIMIT = 4000;
	localparam longint unsigned K_TURNS = 64'd277748430183;
	localparam longint unsigned Q30_ONE = 64'd1073741824;

	typedef struct packed {
		bit        on;
		bit        arm;
		bit [1:0]  stg;
		bit        boost;
		bit [14:0] thr;
		bit [15:0] pit;
		bit [15:0] rol;
	} drive_t;

	typedef struct {
		bit        stop;
		bit [31:0] now;
		bit        typed;
		drive_t    want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic stop_request = 1;
	logic [31:0] now_ms = 0;
	logic out_valid;
	logic out_ready = 0;
	logic motors_on, arm_pulse, angle_boost;
	logic [1:0] stage;
	logic [14:0] throttle;
	logic signed [15:0] pitch, roll;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_STARTUP_MS;
	logic [23:0] cfg_data = 0;

	logic   cur_typed = 0;
	drive_t cur_want;

	test_stand_excitation_sequencer_unit #(.SINE_TABLE_DEPTH(DEPTH)) dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// shadow copy of the sequencer
	bit [15:0] m_startup = RST_STARTUP_MS, m_gap = RST_BURST_GAP_MS, m_len = RST_BURST_LEN_MS;
	bit [23:0] m_chaos = RST_CHAOS_MS;
	bit [11:0] m_settle = RST_SETTLE_STEPS, m_sweep = RST_SWEEP_STEPS;
	bit [1:0]  s_stage = STAGE_SHUTDOWN;
	bit        s_done = 0, s_burst = 0;
	bit [31:0] s_t0 = 0, s_tb = 0;
	bit [2:0]  s_part = PART_SETTLE;
	bit [11:0] s_cnt = 0;
	int        quarter_wave [0:DEPTH];

	drive_t pending_drive [$];
	int     fails = 0;
	int     idle_cycles = 0;
	bit     no_idle = 0;

	function automatic int wave_point(int i);
		longint unsigned a, a2, term, v;
		longint sum;
		a = (longint'(i) * HALF_PI_Q30) / DEPTH;
		a2 = (a * a) >> 30;
		term = a;
		sum = a;
		for (int n = 1; n <= 5; n++) begin
			term = ((term * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2) sum -= term; else sum += term;
		end
		if (sum < 0) sum = 0;
		if (sum > 64'sd1073741824) sum = 64'sd1073741824;
		v = (longint'(sum) * 32767 + 536870912) >> 30;
		if (v > 32767) v = 32767;
		return int'(v);
	endfunction

	function automatic longint sine_of(bit [31:0] p);
		int idx, v;
		idx = int'((longint'(p[29:0]) * DEPTH) >> 30);
		v = p[30] ? quarter_wave[DEPTH - idx] : quarter_wave[idx];
		return p[31] ? -v : v;
	endfunction

	function automatic bit [31:0] turns(bit [31:0] x, int mul, int sh);
		longint unsigned prod;
		prod = longint'(x) * K_TURNS * longint'(mul);
		return 32'(prod >> sh);
	endfunction

	function automatic longint q30_round(longint v);
		v += 536870912;
		if (v >= 0) return v >>> 30;
		return -(((-v) + 1073741823) >>> 30);
	endfunction

	function automatic longint limit(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic drive_t tick_drive(bit stop, bit [31:0] now);
		drive_t r;
		longint s31, s12, s6, s155, sml, med, rolling, big, servo, sp, sv;
		bit [31:0] el;
		r = '{default: 0};
		if (stop) begin
			s_stage = STAGE_SHUTDOWN;
			s_t0 = now;
			return r;
		end
		r.on = 1;
		if (s_stage == STAGE_SHUTDOWN) begin
			r.arm = 1;
			s_stage = STAGE_STARTUP;
			s_t0 = now;
			s_tb = now;
			s_done = 0;
		end
		if (s_stage == STAGE_STARTUP && s_done) begin
			s_stage = STAGE_CHAOS;
			s_t0 = now;
			s_tb = now;
		end else if (s_stage == STAGE_CHAOS && (now - s_t0) > m_chaos) begin
			s_stage = STAGE_SLEW;
			s_part = PART_SETTLE;
			s_cnt = 0;
		end
		if (s_stage == STAGE_STARTUP) begin
			r.thr = 15'(C_STARTUP);
			r.boost = 1;
			if ((now - s_t0) > m_startup) begin
				s_done = 1;
				s_t0 = now;
				s_tb = now;
			end
		end else if (s_stage == STAGE_CHAOS) begin
			s31 = sine_of(turns(now, 20, 18));
			s12 = sine_of(turns(now, 8, 18));
			s6 = sine_of(turns(now, 4, 18));
			s155 = sine_of(turns(now, 1, 18));
			sml = C_SMALL * s31 * s12;
			med = C_MED * s12 * s6;
			rolling = C_ROLLING * s155 * 32768;
			big = 0;
			el = now - s_tb;
			if (s_burst) begin
				big = C_LARGE * sine_of(turns(el, 4, 18)) * 32768;
				if (el >= m_len) begin
					s_burst = 0;
					s_tb = now;
				end
			end else if (el >= m_gap) begin
				s_burst = 1;
				s_tb = now;
			end
			servo = limit(q30_round(sml + med + rolling + big), -C_SERVO_MAX, C_SERVO_MAX);
			r.thr = 15'(limit(q30_round(C_BASE * longint'(Q30_ONE) + sml), C_THR_MIN,
				C_THR_MAX));
			r.pit = 16'(servo);
			r.rol = 16'(servo);
			r.boost = 1;
		end else begin
			r.thr = 15'(C_BASE);
			if (s_part == PART_SETTLE) begin
				r.boost = 1;
				if (s_cnt >= m_settle) begin
					s_part = PART_PITCH;
					s_cnt = 0;
					s_t0 = now;
					s_tb = now;
				end else s_cnt++;
			end else if (s_part == PART_PITCH || s_part == PART_ROLL) begin
				sp = sine_of(turns(32'(s_cnt), 5, 19));
				sv = limit(q30_round(C_SWEEP * sp * 32768), -C_SWEEP, C_SWEEP);
				if (s_part == PART_PITCH) r.pit = 16'(sv); else r.rol = 16'(sv);
				if (s_cnt >= m_sweep) begin
					s_cnt = 0;
					s_part++;
				end else s_cnt++;
			end else if (s_part == PART_THR) begin
				sp = sine_of(turns(32'(s_cnt), 5, 18));
				r.thr = 15'(limit(q30_round(C_BASE * longint'(Q30_ONE) + C_SWING * sp * 32768),
					C_SWEEP_THR_MIN, C_SWEEP_THR_MAX));
				if (s_cnt >= m_settle) begin
					s_cnt = 0;
					s_part = PART_HOLD;
				end else s_cnt++;
			end else begin
				r.boost = 1;
				if (s_cnt >= m_settle) begin
					s_cnt = 0;
					s_t0 = now;
					s_tb = now;
					s_stage = STAGE_CHAOS;
				end else s_cnt++;
			end
		end
		r.stg = s_stage;
		return r;
	endfunction

	always @(posedge clk) begin
		drive_t got, exp_d, pred;
		if (in_valid && in_ready || out_valid && out_ready || cfg_valid && cfg_ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (out_valid && out_ready) begin
			got = '{motors_on, arm_pulse, stage, angle_boost, throttle, pitch, roll};
			if (pending_drive.size() == 0) begin
				$display("%0t unexpected request result %p", $time, got);
				fails++;
			end else begin
				exp_d = pending_drive.pop_front();
				if (got != exp_d) begin
					$display("%0t mismatch expected %p actual %p", $time, exp_d, got);
					fails++;
				end
			end
		end
		if (in_valid && in_ready) begin
			pred = tick_drive(stop_request, now_ms);
			pending_drive.push_back(cur_typed ? cur_want : pred);
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STARTUP_MS:   m_startup = cfg_data[15:0];
				REG_CHAOS_MS:     m_chaos = cfg_data;
				REG_BURST_GAP_MS: m_gap = cfg_data[15:0];
				REG_BURST_LEN_MS: m_len = cfg_data[15:0];
				REG_SETTLE_STEPS: m_settle = cfg_data[11:0];
				REG_SWEEP_STEPS:  m_sweep = cfg_data[11:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pause_len();
		if (no_idle) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 2);
	endfunction

	initial begin
		int n;
		repeat (200) @(posedge clk);
		out_ready <= 0;
		repeat (400) @(posedge clk);
		forever begin
			n = pause_len();
			out_ready <= (n == 0);
			repeat (n == 0 ? $urandom_range(1, 6) : n) @(posedge clk);
		end
	end

	task automatic send(bit stop, bit [31:0] now, bit typed, drive_t want);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		stop_request <= stop;
		now_ms <= now;
		cur_typed <= typed;
		cur_want <= want;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, bit [23:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		cur_typed <= 0;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	row_t   plan [$];
	drive_t off, blank;
	bit [23:0] setups [5][6] = '{
		'{3, 40, 10, 5, 4, 6},
		'{0, 0, 0, 0, 0, 0},
		'{65535, 16777215, 65535, 65535, 4095, 4095},
		'{20, 300, 50, 30, 10, 12},
		'{0, 100, 0, 65535, 2, 3}
	};

	initial begin
		bit [31:0] t;
		bit stop;
		int r;
		off = '{default: 0};
		blank = '{default: 0};
		for (int i = 0; i <= DEPTH; i++) quarter_wave[i] = wave_point(i);
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		plan.push_back('{1, 32'h0000_0000, 1, off});
		plan.push_back('{1, 32'hAAAA_AAAA, 1, off});
		plan.push_back('{1, 32'h5555_5555, 1, off});
		plan.push_back('{0, 32'd0, 1, '{1, 1, STAGE_STARTUP, 1, 15'(C_STARTUP), 0, 0}});
		plan.push_back('{0, 32'd5000, 1, '{1, 0, STAGE_STARTUP, 1, 15'(C_STARTUP), 0, 0}});
		plan.push_back('{0, 32'd5001, 1, '{1, 0, STAGE_STARTUP, 1, 15'(C_STARTUP), 0, 0}});
		plan.push_back('{0, 32'd5002, 0, blank});
		plan.push_back('{0, 32'd5003, 0, blank});
		plan.push_back('{0, 32'hFFFF_FFFF, 1, '{1, 0, STAGE_SLEW, 1, 15'(C_BASE), 0, 0}});
		plan.push_back('{0, 32'hFFFF_FFFF, 0, blank});
		plan.push_back('{1, 32'hFFFF_FFFF, 1, off});
		plan.push_back('{0, 32'h8000_0000, 1, '{1, 1, STAGE_STARTUP, 1, 15'(C_STARTUP), 0, 0}});
		plan.push_back('{0, 32'h8000_2000, 0, blank});
		plan.push_back('{0, 32'h8000_2001, 0, blank});
		plan.push_back('{0, 32'h8001_0000, 0, blank});
		foreach (plan[i]) send(plan[i].stop, plan[i].now, plan[i].typed, plan[i].want);
		drain();

		t = 0;
		for (int ph = 0; ph < 5; ph++) begin
			for (int k = 0; k < 6; k++) write_reg(k[2:0], setups[ph][k]);
			cfg_valid <= 0;
			no_idle = (ph == 3);
			for (int i = 0; i < 120; i++) begin
				r = $urandom_range(0, 99);
				if (r < 85) t += $urandom_range(0, 8);
				else if (r < 96) t += $urandom_range(0, 1000);
				else t = $urandom;
				stop = ($urandom_range(0, 24) == 0);
				send(stop, t, 0, blank);
			end
			drain();
		end

		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
